// ===== src/iqmf_pkg.sv =====
// Package for the IQ magnitude decimating FIR unit.
// Holds shared constants, the coefficient table and the controller/datapath types.
// No dependencies.
package iqmf_pkg;

    localparam int TAPS_DEFAULT        = 144;
    localparam int DECIMATION_DEFAULT  = 8;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int INT_W   = 48;
    localparam int MAG_W   = 18;
    localparam int OUT_W   = 24;
    localparam int COEF_W  = 21;
    localparam int ACC_W   = 56;
    localparam int COEF_COUNT = 72;
    localparam logic [18:0] LEAK_Q32 = 19'd429497;

    // Coefficient for pair k, Q1.23; pairs beyond the table weigh zero.
    function automatic logic signed [COEF_W-1:0] coef_q23(input logic [7:0] k);
        int c;
        begin
            case (k)
                8'd0: c = 273;       8'd1: c = 384;       8'd2: c = 865;
                8'd3: c = 1354;      8'd4: c = 2157;      8'd5: c = 3043;
                8'd6: c = 4152;      8'd7: c = 5261;      8'd8: c = 6377;
                8'd9: c = 7247;      8'd10: c = 7780;     8'd11: c = 7719;
                8'd12: c = 6954;     8'd13: c = 5305;     8'd14: c = 2760;
                8'd15: c = -682;     8'd16: c = -4830;    8'd17: c = -9442;
                8'd18: c = -14098;   8'd19: c = -18349;   8'd20: c = -21649;
                8'd21: c = -23514;   8'd22: c = -23496;   8'd23: c = -21338;
                8'd24: c = -16956;   8'd25: c = -10558;   8'd26: c = -2593;
                8'd27: c = 6199;     8'd28: c = 14899;    8'd29: c = 22440;
                8'd30: c = 27771;    8'd31: c = 29950;    8'd32: c = 28322;
                8'd33: c = 22600;    8'd34: c = 12996;    8'd35: c = 224;
                8'd36: c = -14490;   8'd37: c = -29527;   8'd38: c = -42999;
                8'd39: c = -52985;   8'd40: c = -57746;   8'd41: c = -55991;
                8'd42: c = -47086;   8'd43: c = -31230;   8'd44: c = -9526;
                8'd45: c = 16031;    8'd46: c = 42704;    8'd47: c = 67250;
                8'd48: c = 86270;    8'd49: c = 96601;    8'd50: c = 95751;
                8'd51: c = 82275;    8'd52: c = 56098;    8'd53: c = 18696;
                8'd54: c = -26866;   8'd55: c = -76092;   8'd56: c = -123365;
                8'd57: c = -162440;  8'd58: c = -187022;  8'd59: c = -191445;
                8'd60: c = -171219;  8'd61: c = -123795;  8'd62: c = -48743;
                8'd63: c = 51867;    8'd64: c = 173532;   8'd65: c = 309563;
                8'd66: c = 451561;   8'd67: c = 590128;   8'd68: c = 715577;
                8'd69: c = 818865;   8'd70: c = 892364;   8'd71: c = 930559;
                default: c = 0;
            endcase
            return COEF_W'(c);
        end
    endfunction

    // Controller state, one-hot.
    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_LEAK  = 10'b0000000100,
        ST_DCB   = 10'b0000001000,
        ST_SQR   = 10'b0000010000,
        ST_ROOT  = 10'b0000100000,
        ST_STORE = 10'b0001000000,
        ST_FIR   = 10'b0010000000,
        ST_ROUND = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } iqmf_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture input pair
        logic leak;       // leak products
        logic dcb;        // blocker update and |y| rounding
        logic sqr;        // squares into root unit
        logic root_step;  // one root iteration
        logic store;      // write history
        logic clear;      // write zero at clear pointer
        logic fir_start;  // reset accumulator and tap index
        logic fir_step;   // one MAC step
        logic round;      // round and saturate output
    } iqmf_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic root_done;
        logic emit;
        logic fir_done;
    } iqmf_stat_t;

endpackage

// ===== src/iqmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module iqmf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/iqmf_datapath.sv =====
// Datapath: DC blockers, serial square root, history memory and shared FIR MAC.
// Depends on iqmf_pkg and iqmf_ram.
module iqmf_datapath #(
    parameter int TAPS        = iqmf_pkg::TAPS_DEFAULT,
    parameter int DECIMATION  = iqmf_pkg::DECIMATION_DEFAULT,
    parameter int SAMPLE_BITS = iqmf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iqmf_pkg::iqmf_cmd_t         cmd,
    output iqmf_pkg::iqmf_stat_t        stat,
    input  logic [15:0]                 i_sample,
    input  logic [15:0]                 q_sample,
    output logic signed [iqmf_pkg::OUT_W-1:0] result
);
    import iqmf_pkg::*;

    localparam int AW    = $clog2(TAPS);
    localparam int HALF  = TAPS / 2;
    localparam int KW    = $clog2(HALF + 1);
    localparam int PW    = (DECIMATION > 2) ? $clog2(DECIMATION) : 1;
    localparam int SH    = 33 - SAMPLE_BITS;

    // Integrators and per-item working registers.
    logic signed [INT_W-1:0] i_int_reg, q_int_reg;
    logic signed [INT_W-1:0] xi_reg, xq_reg;
    logic [INT_W-1:0]        mi_leak_reg, mq_leak_reg;
    logic [19:0]             mi_reg, mq_reg;
    logic [32:0]             mi_next, mq_next;
    logic [39:0]             rem_reg, rem_next;
    logic [19:0]             root_reg, root_next;
    logic [5:0]              rstep_reg;
    logic [39:0]             sq_n_reg;
    logic [AW-1:0]           wp_reg, clr_reg;
    logic [PW-1:0]           phase_reg;
    logic                    clear_done_reg;
    logic [KW-1:0]           k_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [MAG_W-1:0]        ha_reg;
    logic [1:0]              rd_side_reg;
    logic signed [OUT_W-1:0] result_reg;

    // Sign-extended samples scaled to Q16.32.
    logic signed [SAMPLE_BITS-1:0] si, sq;
    assign si = i_sample[SAMPLE_BITS-1:0];
    assign sq = q_sample[SAMPLE_BITS-1:0];

    // Leak magnitude: |s| * LEAK / 2^32, split in two 24-bit halves.
    function automatic logic [INT_W-1:0] leak_mag(input logic signed [INT_W-1:0] s);
        logic [INT_W-1:0] a;
        logic [42:0]      p1, p0;
        logic [44:0]      t;
        begin
            a  = s[INT_W-1] ? (~s + 1'b1) : s;
            p1 = a[47:24] * LEAK_Q32;
            p0 = a[23:0] * LEAK_Q32;
            t  = {2'b0, p1} + {21'b0, p0[42:24]} + 45'd128;
            return {11'b0, t[44:8]};
        end
    endfunction

    // Blocker output and saturated integrator update.
    function automatic logic signed [INT_W:0] blk_y(input logic signed [INT_W-1:0] x,
                                                   input logic signed [INT_W-1:0] s,
                                                   input logic [INT_W-1:0] m);
        begin
            return {x[INT_W-1], x} - (s[INT_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m}));
        end
    endfunction

    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W-1:0] s,
                                                       input logic signed [INT_W:0] y);
        logic signed [INT_W+1:0] t;
        begin
            t = {{2{s[INT_W-1]}}, s} + {y[INT_W], y};
            if (t > $signed({3'b000, {(INT_W-1){1'b1}}}))
                return {1'b0, {(INT_W-1){1'b1}}};
            else if (t < $signed({3'b111, {(INT_W-1){1'b0}}}))
                return {1'b1, {(INT_W-1){1'b0}}};
            else
                return t[INT_W-1:0];
        end
    endfunction

    function automatic logic [32:0] q16_mag(input logic signed [INT_W:0] y);
        logic [INT_W:0] a;
        logic [INT_W:0] t;
        begin
            a = y[INT_W] ? (~y + 1'b1) : y;
            t = a + 49'd32768;
            return t[48:16];
        end
    endfunction

    logic signed [INT_W:0] yi, yq;
    assign yi = blk_y(xi_reg, i_int_reg, mi_leak_reg);
    assign yq = blk_y(xq_reg, q_int_reg, mq_leak_reg);
    assign mi_next = q16_mag(yi);
    assign mq_next = q16_mag(yq);

    // Restoring square root, one result bit a step, from bit 19 down.
    logic [39:0] trial;
    logic [19:0] cand;
    always_comb
    begin
        cand = root_reg | (20'd1 << (6'd20 - rstep_reg));
        trial = cand * cand;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (trial <= sq_n_reg)
        begin
            root_next = cand;
        end
    end

    logic [39:0] r_sq, r_err;
    logic [19:0] root_rnd;
    logic [MAG_W-1:0] mag_sat;
    assign r_sq     = root_reg * root_reg;
    assign r_err    = sq_n_reg - r_sq;
    assign root_rnd = (r_err > {20'b0, root_reg}) ? root_reg + 1'b1 : root_reg;
    assign mag_sat  = (root_rnd > 20'h3FFFF) ? {MAG_W{1'b1}} : root_rnd[MAG_W-1:0];

    // History memory.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [MAG_W-1:0] ram_wdata, ram_rdata;
    logic [AW:0]     ia, ib;
    assign ram_we    = cmd.store || cmd.clear;
    assign ram_waddr = cmd.clear ? clr_reg : wp_reg;
    assign ram_wdata = cmd.clear ? '0 : mag_sat;
    assign ia = {1'b0, wp_reg} + (AW+1)'(k_reg);
    assign ib = {1'b0, wp_reg} + (AW+1)'(TAPS - 1) - (AW+1)'(k_reg);
    always_comb
    begin
        if (rd_side_reg[0] == 1'b0)
            ram_raddr = (ia >= (AW+1)'(TAPS)) ? AW'(ia - (AW+1)'(TAPS)) : ia[AW-1:0];
        else
            ram_raddr = (ib >= (AW+1)'(TAPS)) ? AW'(ib - (AW+1)'(TAPS)) : ib[AW-1:0];
    end

    iqmf_ram #(.WIDTH(MAG_W), .DEPTH(TAPS)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Product of a coefficient and a pair sum.
    logic signed [COEF_W+MAG_W+1:0] prod;
    assign prod = coef_reg * $signed({1'b0, {1'b0, ha_reg} + {1'b0, ram_rdata}});

    logic signed [ACC_W:0] biased;
    logic signed [ACC_W-19:0] shifted;
    assign biased  = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(262144);
    assign shifted = biased[ACC_W:19];

    // Sequential datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_int_reg      <= '0;
            q_int_reg      <= '0;
            wp_reg         <= '0;
            clr_reg        <= '0;
            phase_reg      <= '0;
            clear_done_reg <= 1'b0;
            rstep_reg      <= '0;
            k_reg          <= '0;
            rd_side_reg    <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == AW'(TAPS - 1))
                    clear_done_reg <= 1'b1;
            end
            if (cmd.dcb)
            begin
                i_int_reg <= sat_int(i_int_reg, yi);
                q_int_reg <= sat_int(q_int_reg, yq);
            end
            if (cmd.sqr)
                rstep_reg <= '0;
            else if (cmd.root_step)
                rstep_reg <= rstep_reg + 1'b1;
            if (cmd.store)
            begin
                wp_reg    <= (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                phase_reg <= (phase_reg >= PW'(DECIMATION - 1)) ? '0 : phase_reg + 1'b1;
            end
            if (cmd.fir_start)
            begin
                k_reg         <= '0;
                rd_side_reg   <= '0;
            end
            else if (cmd.fir_step)
            begin
                // Four phases per pair: read a, read b, hold b and reread a, MAC.
                rd_side_reg   <= rd_side_reg + 1'b1;
                if (rd_side_reg == 2'd3)
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xi_reg <= INT_W'(si) <<< SH;
            xq_reg <= INT_W'(sq) <<< SH;
        end
        if (cmd.leak)
        begin
            mi_leak_reg <= leak_mag(i_int_reg);
            mq_leak_reg <= leak_mag(q_int_reg);
        end
        // |y| stays below 2^35, so the rounded magnitude fits in 20 bits.
        if (cmd.dcb)
        begin
            mi_reg <= mi_next[19:0];
            mq_reg <= mq_next[19:0];
        end
        if (cmd.sqr)
        begin
            sq_n_reg <= mi_reg * mi_reg;
            rem_reg  <= mq_reg * mq_reg;
            root_reg <= '0;
        end
        else if (rstep_reg == 6'd0 && cmd.root_step)
        begin
            sq_n_reg <= sq_n_reg + rem_reg;
        end
        else if (cmd.root_step)
        begin
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
        if (cmd.fir_start)
            acc_reg <= '0;
        else if (cmd.fir_step)
        begin
            if (rd_side_reg == 2'd1)
                coef_reg <= (KW'(k_reg) < KW'(COEF_COUNT)) ? coef_q23(8'(k_reg)) : '0;
            if (rd_side_reg == 2'd2)
                ha_reg <= ram_rdata;
            if (rd_side_reg == 2'd3)
                acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (cmd.round)
        begin
            if (shifted > $signed((ACC_W-18)'(8388607)))
                result_reg <= 24'sh7FFFFF;
            else if (shifted < -$signed((ACC_W-18)'(8388608)))
                result_reg <= 24'sh800000;
            else
                result_reg <= shifted[OUT_W-1:0];
        end
    end

    assign result          = result_reg;
    assign stat.clear_done = clear_done_reg;
    assign stat.root_done  = (rstep_reg == 6'd21);
    assign stat.emit       = (phase_reg >= PW'(DECIMATION - 1));
    assign stat.fir_done   = (k_reg == KW'(HALF));

`ifndef SYNTH
    // Write pointer stays inside the history.
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < (AW+1)'(TAPS)) else $error("write pointer out of range");
    // Decimation phase stays inside its period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg} < (PW+1)'(DECIMATION)) else $error("phase out of range");
    // Root counter never runs past its final step.
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rstep_reg <= 6'd21) else $error("root counter overran");
`endif
endmodule

// ===== src/iqmf_ctrl.sv =====
// Controller state machine sequencing blocker, root, store and FIR steps.
// Depends on iqmf_pkg.
module iqmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  iqmf_pkg::iqmf_stat_t  stat,
    output iqmf_pkg::iqmf_cmd_t   cmd
);
    import iqmf_pkg::*;

    iqmf_state_t state_reg, state_next;
    logic        out_v_reg, out_v_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        out_v_next = out_v_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        if (out_v_reg && m_tready)
            out_v_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = !stat.clear_done;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LEAK;
                end
            end
            ST_LEAK:
            begin
                cmd.leak   = 1'b1;
                state_next = ST_DCB;
            end
            ST_DCB:
            begin
                cmd.dcb    = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sqr    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (stat.root_done)
                    state_next = ST_STORE;
                else
                    cmd.root_step = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = stat.emit ? ST_FIR : ST_IDLE;
                cmd.fir_start = stat.emit;
            end
            ST_FIR:
            begin
                // The result register is only rewritten once the previous
                // output transfer has gone.
                if (stat.fir_done)
                begin
                    if (!out_v_reg || m_tready)
                        state_next = ST_ROUND;
                end
                else
                    cmd.fir_step = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end

    assign m_tvalid = out_v_reg;

`ifndef SYNTH
    // State register is always one-hot.
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    // Inputs are only taken in idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    // A waiting result is not overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule

// ===== src/iq_magnitude_decimating_fir_unit.sv =====
// Top level of the IQ magnitude decimating FIR unit.
// Depends on iqmf_pkg, iqmf_ctrl, iqmf_datapath and iqmf_ram.
//
// Takes one I/Q pair per transfer, DC-blocks each channel, writes the
// magnitude into a TAPS-deep history and every DECIMATION-th pair produces
// one saturated FIR output transfer. After reset a clearing pass zeroes
// the history before the first transfer is taken. Each item includes a
// bit-serial square root; an emitting item adds a pass of the single
// shared MAC, which works through the symmetric tap pairs one at a time,
// and it waits further while the previous output transfer is still pending.
module iq_magnitude_decimating_fir_unit #(
    parameter int TAPS        = iqmf_pkg::TAPS_DEFAULT,
    parameter int DECIMATION  = iqmf_pkg::DECIMATION_DEFAULT,
    parameter int SAMPLE_BITS = iqmf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] i_sample, [31:16] q_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [23:0] filtered_magnitude
);
    import iqmf_pkg::*;

    iqmf_cmd_t  cmd;
    iqmf_stat_t stat;
    logic signed [OUT_W-1:0] result;

    iqmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iqmf_datapath #(
        .TAPS        (TAPS),
        .DECIMATION  (DECIMATION),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .i_sample (s_tdata[15:0]),
        .q_sample (s_tdata[31:16]),
        .result   (result)
    );

    assign m_tdata = result;
endmodule
